[rtl/svpwm_pkg.sv]
// Shared types and constants for the space vector PWM duty pipeline.
package svpwm_pkg;

	// Valid and fault flags that travel with each request down the pipeline.
	typedef struct packed {
		logic vld;
		logic flt;
	} ctrl_t;

	// Q16 constants: 1.5, sqrt(3) and sqrt(3)/2, rounded to nearest.
	localparam logic [16:0] K_1P5_Q16     = 17'd98304;
	localparam logic [16:0] K_SQRT3_Q16   = 17'd113512;
	localparam logic [16:0] K_SQRT3_2_Q16 = 17'd56756;

	// Sector codes.
	localparam logic [2:0] SEC_1 = 3'd1;
	localparam logic [2:0] SEC_2 = 3'd2;
	localparam logic [2:0] SEC_3 = 3'd3;
	localparam logic [2:0] SEC_4 = 3'd4;
	localparam logic [2:0] SEC_5 = 3'd5;
	localparam logic [2:0] SEC_6 = 3'd6;

endpackage

[rtl/space_vector_pwm_duty.sv]
// Space vector PWM duty generator: top level with products, sector, duty and output stages.
// A request passes the divider stages, then the products, sector, duty and output registers.
// It takes one request per cycle while the result is not stalled; the divider retires one quotient bit per stage.
// The whole pipeline advances whenever the output register is empty or being taken.
// Reset clears all valid flags asynchronously; payload registers are not reset.
module space_vector_pwm_duty import svpwm_pkg::*; #(
	parameter int VOLT_WIDTH = 16,
	parameter int FRAC_BITS  = 15
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [VOLT_WIDTH-1:0] volt_alpha,
	input  logic signed [VOLT_WIDTH-1:0] volt_beta,
	input  logic        [VOLT_WIDTH-2:0] supply_volts,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic        [15:0]           duty_u,
	output logic        [15:0]           duty_v,
	output logic        [15:0]           duty_w,
	output logic        [2:0]            sector_num,
	output logic                         supply_fault
);

	localparam int AW = FRAC_BITS + 3;
	localparam int MW = AW + 18;
	localparam int PW = FRAC_BITS + 22;
	localparam logic signed [PW-1:0] ONE = PW'(1) <<< (FRAC_BITS + 16);
	localparam logic signed [PW-1:0] HALF_LSB = PW'(32768);

	logic en;
	ctrl_t div_ctl;
	logic signed [AW-1:0] ratio_a, ratio_b;

	// One enable moves every stage; a stalled result holds the whole pipeline.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	svpwm_div #(
		.VOLT_WIDTH(VOLT_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_vld      (in_valid),
		.volt_alpha  (volt_alpha),
		.volt_beta   (volt_beta),
		.supply_volts(supply_volts),
		.out_ctl     (div_ctl),
		.ratio_a     (ratio_a),
		.ratio_b     (ratio_b)
	);

	// Products stage: scaled ratios for the sector test and the active times.
	ctrl_t ctl_s2;
	logic signed [PW-1:0] ha_s2, sb_s2, hb_s2, ra_s2, bs_s2;
	logic ap_s2, bp_s2;
	logic signed [MW-1:0] ha_m, sb_m, hb_m, ra_m;

	assign ha_m = ratio_a * $signed({1'b0, K_1P5_Q16});
	assign sb_m = ratio_b * $signed({1'b0, K_SQRT3_Q16});
	assign hb_m = ratio_b * $signed({1'b0, K_SQRT3_2_Q16});
	assign ra_m = ratio_a * $signed({1'b0, K_SQRT3_Q16});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= div_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ha_s2 <= PW'(ha_m);
			sb_s2 <= PW'(sb_m);
			hb_s2 <= PW'(hb_m);
			ra_s2 <= PW'(ra_m);
			bs_s2 <= PW'(ratio_b) <<< 16;
			ap_s2 <= !ratio_a[AW-1] && (ratio_a != '0);
			bp_s2 <= !ratio_b[AW-1] && (ratio_b != '0);
		end
	end

	// Sector stage: strict comparisons pick the sector, then its two active times.
	// Odd sectors subtract t1 then t2 from the leading duty, even sectors the reverse.
	ctrl_t ctl_s3;
	logic [2:0] sec_s3;
	logic signed [PW-1:0] tx_s3, ty_s3;
	logic [2:0] sec_c;
	logic signed [PW-1:0] t1_c, t2_c;

	always_comb begin
		priority if (bp_s2 && ap_s2) begin
			sec_c = (bs_s2 > ra_s2) ? SEC_2 : SEC_1;
		end else if (bp_s2) begin
			sec_c = (bs_s2 > -ra_s2) ? SEC_2 : SEC_3;
		end else if (ap_s2) begin
			sec_c = (bs_s2 > -ra_s2) ? SEC_6 : SEC_5;
		end else begin
			sec_c = (bs_s2 > ra_s2) ? SEC_4 : SEC_5;
		end
	end

	always_comb begin
		unique case (sec_c)
			SEC_1: begin
				t1_c = ha_s2 - hb_s2;
				t2_c = sb_s2;
			end
			SEC_2: begin
				t1_c = ha_s2 + hb_s2;
				t2_c = hb_s2 - ha_s2;
			end
			SEC_3: begin
				t1_c = sb_s2;
				t2_c = -ha_s2 - hb_s2;
			end
			SEC_4: begin
				t1_c = hb_s2 - ha_s2;
				t2_c = -sb_s2;
			end
			SEC_5: begin
				t1_c = -ha_s2 - hb_s2;
				t2_c = ha_s2 - hb_s2;
			end
			default: begin
				t1_c = -sb_s2;
				t2_c = ha_s2 + hb_s2;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sec_s3 <= sec_c;
			tx_s3  <= sec_c[0] ? t1_c : t2_c;
			ty_s3  <= sec_c[0] ? t2_c : t1_c;
		end
	end

	// Duty stage: leading duty is the centered half sum, the others step down from it.
	ctrl_t ctl_s4;
	logic [2:0] sec_s4;
	logic signed [PW-1:0] dl_s4, dm_s4, dt_s4;
	logic signed [PW-1:0] lead_c, mid_c;

	assign lead_c = (ONE + tx_s3 + ty_s3) >>> 1;
	assign mid_c  = lead_c - tx_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sec_s4 <= sec_s3;
			dl_s4  <= lead_c;
			dm_s4  <= mid_c;
			dt_s4  <= mid_c - ty_s3;
		end
	end

	// Output stage: route duties to phases, clamp to 0..1, round to the field, zero on a supply fault.
	ctrl_t ctl_s5;
	logic signed [PW-1:0] du_c, dv_c, dw_c;

	function automatic logic [15:0] finish(input logic signed [PW-1:0] x);
		logic signed [PW-1:0] c;
		logic [PW-1:0] r;
		begin
			c = x;
			if (x < 0) begin
				c = '0;
			end else if (x > ONE) begin
				c = ONE;
			end
			r = ($unsigned(c) + $unsigned(HALF_LSB)) >> 16;
			finish = r[15:0];
		end
	endfunction

	always_comb begin
		unique case (sec_s4)
			SEC_1: begin
				du_c = dl_s4; dv_c = dm_s4; dw_c = dt_s4;
			end
			SEC_2: begin
				dv_c = dl_s4; du_c = dm_s4; dw_c = dt_s4;
			end
			SEC_3: begin
				dv_c = dl_s4; dw_c = dm_s4; du_c = dt_s4;
			end
			SEC_4: begin
				dw_c = dl_s4; dv_c = dm_s4; du_c = dt_s4;
			end
			SEC_5: begin
				dw_c = dl_s4; du_c = dm_s4; dv_c = dt_s4;
			end
			default: begin
				du_c = dl_s4; dw_c = dm_s4; dv_c = dt_s4;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5 <= '0;
		end else if (en) begin
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			duty_u     <= ctl_s4.flt ? 16'd0 : finish(du_c);
			duty_v     <= ctl_s4.flt ? 16'd0 : finish(dv_c);
			duty_w     <= ctl_s4.flt ? 16'd0 : finish(dw_c);
			sector_num <= sec_s4;
		end
	end

	assign out_valid    = ctl_s5.vld;
	assign supply_fault = ctl_s5.flt;

endmodule

[rtl/svpwm_div.sv]
// Pipelined restoring divider that turns alpha and beta voltages into saturated ratios.
module svpwm_div import svpwm_pkg::*; #(
	parameter int VOLT_WIDTH = 16,
	parameter int FRAC_BITS  = 15
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_vld,
	input  logic signed [VOLT_WIDTH-1:0] volt_alpha,
	input  logic signed [VOLT_WIDTH-1:0] volt_beta,
	input  logic        [VOLT_WIDTH-2:0] supply_volts,
	output ctrl_t                        out_ctl,
	output logic signed [FRAC_BITS+2:0]  ratio_a,
	output logic signed [FRAC_BITS+2:0]  ratio_b
);

	localparam int QW = FRAC_BITS + 2;
	localparam int RW = VOLT_WIDTH + 2;
	localparam logic [QW-1:0] LIM = {2'b10, {FRAC_BITS{1'b0}}};

	logic [VOLT_WIDTH-1:0] mag_a, mag_b;
	logic [RW-1:0]         sup_ext;

	ctrl_t          ctl_s   [0:QW];
	logic           neg_a_s [0:QW];
	logic           neg_b_s [0:QW];
	logic           sat_a_s [0:QW];
	logic           sat_b_s [0:QW];
	logic [RW-1:0]  sup_s   [0:QW];
	logic [RW-1:0]  rem_a_s [0:QW];
	logic [RW-1:0]  rem_b_s [0:QW];
	logic [QW-1:0]  quo_a_s [0:QW];
	logic [QW-1:0]  quo_b_s [0:QW];

	// Magnitudes of the two components and the widened divisor.
	assign mag_a   = volt_alpha[VOLT_WIDTH-1] ? (~volt_alpha + 1'b1) : volt_alpha;
	assign mag_b   = volt_beta[VOLT_WIDTH-1]  ? (~volt_beta + 1'b1)  : volt_beta;
	assign sup_ext = {3'b000, supply_volts};

	// First stage: register magnitudes, signs and the saturation test mag >= 4 * supply.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (en) begin
			ctl_s[0].vld <= in_vld;
			ctl_s[0].flt <= (supply_volts == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_a_s[0] <= volt_alpha[VOLT_WIDTH-1];
			neg_b_s[0] <= volt_beta[VOLT_WIDTH-1];
			sat_a_s[0] <= ({2'b00, mag_a} >= (sup_ext << 2));
			sat_b_s[0] <= ({2'b00, mag_b} >= (sup_ext << 2));
			sup_s[0]   <= sup_ext;
			rem_a_s[0] <= {2'b00, mag_a};
			rem_b_s[0] <= {2'b00, mag_b};
			quo_a_s[0] <= '0;
			quo_b_s[0] <= '0;
		end
	end

	// One quotient bit per stage. The first two stages resolve the integer part
	// against twice and once the divisor, the rest shift the remainder up.
	for (genvar i = 0; i < QW; i++) begin : g_step
		logic [RW-1:0] trial_a, trial_b, dvs;
		logic          bit_a, bit_b;

		if (i < 2) begin : g_int
			assign trial_a = rem_a_s[i];
			assign trial_b = rem_b_s[i];
			assign dvs     = sup_s[i] << (1 - i);
		end else begin : g_frac
			assign trial_a = rem_a_s[i] << 1;
			assign trial_b = rem_b_s[i] << 1;
			assign dvs     = sup_s[i];
		end

		assign bit_a = (trial_a >= dvs);
		assign bit_b = (trial_b >= dvs);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i+1] <= '0;
			end else if (en) begin
				ctl_s[i+1] <= ctl_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				neg_a_s[i+1] <= neg_a_s[i];
				neg_b_s[i+1] <= neg_b_s[i];
				sat_a_s[i+1] <= sat_a_s[i];
				sat_b_s[i+1] <= sat_b_s[i];
				sup_s[i+1]   <= sup_s[i];
				rem_a_s[i+1] <= bit_a ? (trial_a - dvs) : trial_a;
				rem_b_s[i+1] <= bit_b ? (trial_b - dvs) : trial_b;
				quo_a_s[i+1] <= {quo_a_s[i][QW-2:0], bit_a};
				quo_b_s[i+1] <= {quo_b_s[i][QW-2:0], bit_b};
			end
		end
	end

	// Saturate to two, apply the sign, and force zero on a supply fault.
	logic [QW-1:0]             qa_sat, qb_sat;
	logic signed [FRAC_BITS+2:0] ra_next, rb_next;

	assign qa_sat  = (sat_a_s[QW] || (quo_a_s[QW] > LIM)) ? LIM : quo_a_s[QW];
	assign qb_sat  = (sat_b_s[QW] || (quo_b_s[QW] > LIM)) ? LIM : quo_b_s[QW];
	assign ra_next = ctl_s[QW].flt ? '0 :
		(neg_a_s[QW] ? -$signed({1'b0, qa_sat}) : $signed({1'b0, qa_sat}));
	assign rb_next = ctl_s[QW].flt ? '0 :
		(neg_b_s[QW] ? -$signed({1'b0, qb_sat}) : $signed({1'b0, qb_sat}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ctl <= '0;
		end else if (en) begin
			out_ctl <= ctl_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ratio_a <= ra_next;
			ratio_b <= rb_next;
		end
	end

endmodule

[tb/space_vector_pwm_duty_test.sv]
// Self-checking testbench for the space vector PWM duty generator.
`timescale 1ns / 1ps

// Predicts duties and sector per request and checks results in order.
class duty_scoreboard;
	typedef struct {
		logic [15:0] du, dv, dw;
		logic [2:0]  sec;
		logic        flt;
	} duty_t;

	duty_t pending[$];
	int    errors;

	// Per-unit ratio: magnitude over supply, truncated, saturated at two.
	static function longint unit_ratio(logic signed [15:0] v, logic [14:0] sup);
		longint mag, q;
		mag = (v < 0) ? -longint'(v) : longint'(v);
		q = (mag <<< 15) / longint'(sup);
		if (q > (2 <<< 15))
			q = 2 <<< 15;
		return (v < 0) ? -q : q;
	endfunction

	static function logic [2:0] sector_of(longint a, longint b);
		longint bs, ra;
		bs = b * 65536;
		ra = longint'(svpwm_pkg::K_SQRT3_Q16) * a;
		if (b > 0) begin
			if (a > 0)
				return (bs > ra) ? svpwm_pkg::SEC_2 : svpwm_pkg::SEC_1;
			return (bs > -ra) ? svpwm_pkg::SEC_2 : svpwm_pkg::SEC_3;
		end
		if (a > 0)
			return (bs > -ra) ? svpwm_pkg::SEC_6 : svpwm_pkg::SEC_5;
		return (bs > ra) ? svpwm_pkg::SEC_4 : svpwm_pkg::SEC_5;
	endfunction

	// Clamp to 0..1 and round to nearest in Q1.15.
	static function logic [15:0] to_duty(longint x);
		longint full;
		full = longint'(1) <<< 31;
		if (x < 0)
			x = 0;
		if (x > full)
			x = full;
		return 16'((x + 32768) >>> 16);
	endfunction

	// Notes an accepted request and stores its expected result.
	function void note_request(logic signed [15:0] va, logic signed [15:0] vb,
			logic [14:0] sup);
		duty_t  e;
		longint a, b, ha, sb, hb, t1, t2, d0, d1, d2, full;
		full = longint'(1) <<< 31;
		if (sup == 0) begin
			e = '{16'd0, 16'd0, 16'd0, sector_of(0, 0), 1'b1};
		end else begin
			a = unit_ratio(va, sup);
			b = unit_ratio(vb, sup);
			e.sec = sector_of(a, b);
			e.flt = 1'b0;
			ha = longint'(svpwm_pkg::K_1P5_Q16) * a;
			sb = longint'(svpwm_pkg::K_SQRT3_Q16) * b;
			hb = longint'(svpwm_pkg::K_SQRT3_2_Q16) * b;
			case (e.sec)
				svpwm_pkg::SEC_1: begin
					t1 = ha - hb; t2 = sb;
					d0 = (full + t1 + t2) / 2; d1 = d0 - t1; d2 = d1 - t2;
				end
				svpwm_pkg::SEC_2: begin
					t1 = ha + hb; t2 = -ha + hb;
					d1 = (full + t1 + t2) / 2; d0 = d1 - t2; d2 = d0 - t1;
				end
				svpwm_pkg::SEC_3: begin
					t1 = sb; t2 = -ha - hb;
					d1 = (full + t1 + t2) / 2; d2 = d1 - t1; d0 = d2 - t2;
				end
				svpwm_pkg::SEC_4: begin
					t1 = -ha + hb; t2 = -sb;
					d2 = (full + t1 + t2) / 2; d1 = d2 - t2; d0 = d1 - t1;
				end
				svpwm_pkg::SEC_5: begin
					t1 = -ha - hb; t2 = ha - hb;
					d2 = (full + t1 + t2) / 2; d0 = d2 - t1; d1 = d0 - t2;
				end
				default: begin
					t1 = -sb; t2 = ha + hb;
					d0 = (full + t1 + t2) / 2; d2 = d0 - t2; d1 = d2 - t1;
				end
			endcase
			e.du = to_duty(d0);
			e.dv = to_duty(d1);
			e.dw = to_duty(d2);
		end
		pending.push_back(e);
	endfunction

	// Compares one result with the oldest expectation.
	function void check_result(logic [15:0] du, logic [15:0] dv, logic [15:0] dw,
			logic [2:0] sec, logic flt);
		duty_t e;
		if (pending.size() == 0) begin
			$error("result with no request outstanding");
			errors++;
			return;
		end
		e = pending.pop_front();
		if (du !== e.du) begin
			$error("duty_u expected %0d got %0d", e.du, du); errors++;
		end
		if (dv !== e.dv) begin
			$error("duty_v expected %0d got %0d", e.dv, dv); errors++;
		end
		if (dw !== e.dw) begin
			$error("duty_w expected %0d got %0d", e.dw, dw); errors++;
		end
		if (sec !== e.sec) begin
			$error("sector_num expected %0d got %0d", e.sec, sec); errors++;
		end
		if (flt !== e.flt) begin
			$error("supply_fault expected %0d got %0d", e.flt, flt); errors++;
		end
	endfunction
endclass

module space_vector_pwm_duty_test;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] volt_alpha = '0;
	logic signed [15:0] volt_beta = '0;
	logic [14:0] supply_volts = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [15:0] duty_u, duty_v, duty_w;
	logic [2:0] sector_num;
	logic supply_fault;

	duty_scoreboard board = new();
	int send_idle_pct = 35;
	int recv_idle_pct = 79;
	bit hold_off = 1'b0;

	space_vector_pwm_duty dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offers one request and waits until it is taken; valid drops only while idling.
	task automatic send_vector(logic signed [15:0] va, logic signed [15:0] vb,
			logic [14:0] sup);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		volt_alpha <= va;
		volt_beta <= vb;
		supply_volts <= sup;
		do
			@(posedge clk);
		while (!in_ready);
		board.note_request(va, vb, sup);
	endtask

	// Random vector: mostly moderate magnitudes, sometimes zero supply, a zero component or any bit pattern.
	task automatic send_random();
		logic [14:0] sup;
		logic signed [15:0] va, vb;
		int mode;
		mode = $urandom_range(9);
		va = 16'($urandom);
		vb = 16'($urandom);
		sup = 15'($urandom);
		if (mode < 6) begin
			sup = 15'($urandom_range(32767, 1000));
			va = $signed(16'($urandom_range(2 * sup))) - $signed(16'(sup));
			vb = $signed(16'($urandom_range(2 * sup))) - $signed(16'(sup));
		end else if (mode == 6) begin
			sup = '0;
		end else if (mode == 7) begin
			vb = '0;
		end else if (mode == 8) begin
			va = '0;
		end
		send_vector(va, vb, sup);
	endtask

	// Result side: random ready, checked on each accepted result.
	always @(posedge clk) begin
		if (out_valid && out_ready)
			board.check_result(duty_u, duty_v, duty_w, sector_num, supply_fault);
		out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
	end

	// Long receiver hold-off so the pipeline fills and stalls its input.
	initial begin
		wait (arst_n);
		repeat (300) @(posedge clk);
		hold_off = 1'b1;
		repeat (200) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int n;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed: extremes, zero supply, axis and boundary vectors.
		send_vector(16'sh7FFF, 16'sh7FFF, 15'h7FFF);
		send_vector(-16'sh8000, -16'sh8000, 15'd1);
		send_vector(16'sh7FFF, -16'sh8000, 15'd1);
		send_vector(-16'sh8000, 16'sh7FFF, 15'd100);
		send_vector(16'sd0, 16'sd0, 15'd0);
		send_vector(16'sh7FFF, 16'sh7FFF, 15'd0);
		send_vector(16'sd0, 16'sd0, 15'd1000);
		send_vector(16'sd1000, 16'sd0, 15'd1000);
		send_vector(-16'sd1000, 16'sd0, 15'd1000);
		send_vector(16'sd0, 16'sd1000, 15'd1000);
		send_vector(16'sd0, -16'sd1000, 15'd1000);
		send_vector(16'sd1000, 16'sd1732, 15'd4000);
		send_vector(-16'sd1000, 16'sd1732, 15'd4000);
		send_vector(16'sd1000, -16'sd1732, 15'd4000);
		send_vector(-16'sd1000, -16'sd1732, 15'd4000);
		send_vector(16'sd300, 16'sd100, 15'd1000);
		send_vector(16'sd100, 16'sd300, 15'd1000);
		send_vector(-16'sd300, 16'sd100, 15'd1000);
		send_vector(-16'sd300, -16'sd100, 15'd1000);
		send_vector(16'sd300, -16'sd100, 15'd1000);
		send_vector(16'sd5, 16'sd3, 15'h7FFF);
		// Random phases with changing idle rates.
		for (n = 0; n < 310; n++)
			send_random();
		send_idle_pct = 79;
		recv_idle_pct = 35;
		for (n = 0; n < 310; n++)
			send_random();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (n = 0; n < 310; n++)
			send_random();
		in_valid <= 1'b0;
		wait (board.pending.size() == 0);
		repeat (40) @(posedge clk);
		if (board.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
